// ===== design/sqb_pkg.sv =====
// Shared types and constants of the sprite quad batcher.
package sqb_pkg;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_FLUSH  = 2'd1;
  localparam logic [1:0] KIND_BIND   = 2'd2;

  localparam int unsigned CORNERS = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_FLUSH  = 2'd0,
    CMD_BIND   = 2'd1,
    CMD_SPRITE = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic               last;
    logic [2:0]         slot;
    logic [15:0]        handle;
    logic [12:0]        batch_vertices;
    logic [3:0]         batch_textures;
    logic [15:0]        angle;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [19:0]        width;
    logic [19:0]        height;
    logic [15:0]        uv_left;
    logic [15:0]        uv_top;
    logic [16:0]        uv_right;
    logic [16:0]        uv_bottom;
  } cmd_t;

endpackage

// ===== design/sqb_queue.sv =====
// Short command queue between the front and back parts.
module sqb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sqb_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sqb_pkg::cmd_t data_o
);
  import sqb_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

// ===== design/sqb_front.sv =====
// Front part: accepts words, decides flushes, looks up or binds texture slots.
module sqb_front #(
  parameter int unsigned MAX_SPRITES = 1024,
  parameter int unsigned TEX_SLOTS   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [15:0]        texture_handle_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [19:0]        width_i,
  input  logic [19:0]        height_i,
  input  logic [15:0]        angle_i,
  input  logic [15:0]        uv_left_i,
  input  logic [15:0]        uv_top_i,
  input  logic [15:0]        uv_width_i,
  input  logic [15:0]        uv_height_i,
  output logic               push_o,
  output sqb_pkg::cmd_t      cmd_o,
  input  logic               full_i
);
  import sqb_pkg::*;

  localparam int unsigned VcW  = $clog2(CORNERS * MAX_SPRITES + 1);
  localparam int unsigned SuW  = $clog2(TEX_SLOTS + 1);
  localparam int unsigned IdxW = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam logic [VcW-1:0] VcLimit = VcW'(CORNERS * MAX_SPRITES);

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_FLUSH  = 4'b0010,
    F_BIND   = 4'b0100,
    F_SPRITE = 4'b1000
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [VcW-1:0]     vc_q, vc_d;
  logic [SuW-1:0]     su_q, su_d;
  logic [15:0]        table_q [TEX_SLOTS];
  logic               tbl_we;
  logic [2:0]         slot_q, slot_d;
  logic               mode_q;
  logic [15:0]        handle_q, angle_q, ul_q, vt_q, uw_q, vh_q;
  logic signed [23:0] px_q, py_q;
  logic [19:0]        w_q, h_q;
  logic               found;
  logic [IdxW-1:0]    hit_idx;

  assign in_ready_o = (state_q == F_IDLE);

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = TEX_SLOTS - 1; i >= 0; i--) begin
      if ((SuW'(i) < su_q) && (table_q[i] == handle_q)) begin
        found   = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    vc_d    = vc_q;
    su_d    = su_q;
    slot_d  = slot_q;
    tbl_we  = 1'b0;
    push_o  = 1'b0;
    cmd_o   = '0;
    cmd_o.op             = CMD_FLUSH;
    cmd_o.slot           = slot_q;
    cmd_o.handle         = handle_q;
    cmd_o.batch_vertices = 13'(vc_q);
    cmd_o.batch_textures = 4'(su_q);
    cmd_o.angle          = angle_q;
    cmd_o.pos_x          = px_q;
    cmd_o.pos_y          = py_q;
    cmd_o.width          = w_q;
    cmd_o.height         = h_q;
    cmd_o.uv_left        = ul_q;
    cmd_o.uv_top         = vt_q;
    cmd_o.uv_right       = {1'b0, ul_q} + {1'b0, uw_q};
    cmd_o.uv_bottom      = {1'b0, vt_q} + {1'b0, vh_q};
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_FLUSH;
      end
      F_FLUSH: begin
        if (mode_q) begin
          cmd_o.last = 1'b1;
          if (vc_q == '0) begin
            state_d = F_IDLE;
          end else if (!full_i) begin
            push_o  = 1'b1;
            vc_d    = '0;
            su_d    = '0;
            state_d = F_IDLE;
          end
        end else if ((vc_q >= VcLimit) || (su_q >= SuW'(TEX_SLOTS))) begin
          if (!full_i) begin
            push_o  = 1'b1;
            vc_d    = '0;
            su_d    = '0;
            state_d = F_BIND;
          end
        end else begin
          state_d = F_BIND;
        end
      end
      F_BIND: begin
        cmd_o.op   = CMD_BIND;
        cmd_o.slot = 3'(su_q);
        if (found) begin
          slot_d  = 3'(hit_idx);
          state_d = F_SPRITE;
        end else if (!full_i) begin
          push_o  = 1'b1;
          tbl_we  = 1'b1;
          slot_d  = 3'(su_q);
          su_d    = su_q + 1'b1;
          state_d = F_SPRITE;
        end
      end
      F_SPRITE: begin
        cmd_o.op   = CMD_SPRITE;
        cmd_o.last = 1'b1;
        if (!full_i) begin
          push_o  = 1'b1;
          vc_d    = vc_q + VcW'(CORNERS);
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      handle_q <= texture_handle_i;
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      w_q      <= width_i;
      h_q      <= height_i;
      angle_q  <= angle_i;
      ul_q     <= uv_left_i;
      vt_q     <= uv_top_i;
      uw_q     <= uv_width_i;
      vh_q     <= uv_height_i;
    end
    if (tbl_we) begin
      table_q[su_q[IdxW-1:0]] <= handle_q;
    end
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      vc_q    <= '0;
      su_q    <= '0;
    end else begin
      state_q <= state_d;
      vc_q    <= vc_d;
      su_q    <= su_d;
    end
  end
endmodule

// ===== design/sqb_back.sv =====
// Back part: computes sine and cosine, rotates corners and emits result words.
module sqb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sqb_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [23:0] vert_x_o,
  output logic signed [23:0] vert_y_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [2:0]         slot_o,
  output logic [15:0]        bound_handle_o,
  output logic [12:0]        batch_vertices_o,
  output logic [3:0]         batch_textures_o,
  output logic               last_o
);
  import sqb_pkg::*;

  localparam logic [3:0] StZ2F = 4'd0, StT1F = 4'd1, StT2F = 4'd2, StPF = 4'd3;
  localparam logic [3:0] StZ2G = 4'd4, StT1G = 4'd5, StT2G = 4'd6, StPG = 4'd7;
  localparam logic [3:0] StTrig = 4'd8, StWc = 4'd9, StWs = 4'd10, StHs = 4'd11;
  localparam logic [3:0] StHc = 4'd12, StRound = 4'd13;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CALC = 3'b010,
    B_EMIT = 3'b100
  } back_state_e;

  back_state_e        state_q;
  cmd_t               cmd_q;
  logic [3:0]         step_q;
  logic [1:0]         corner_q;
  logic [14:0]        z2_q, pf_q, pg_q;
  logic [15:0]        t_q;
  logic signed [16:0] cs_q, sn_q;
  logic signed [37:0] wc_q, ws_q, hs_q, hc_q;
  logic signed [21:0] rx_q [1:3];
  logic signed [21:0] ry_q [1:3];
  logic signed [20:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [37:0] prod;
  logic signed [23:0] shr;
  logic [14:0]        clamped;
  logic [14:0]        f_val;
  logic [14:0]        g_val;
  logic               out_free;
  logic               load;
  cmd_t               ld_cmd;
  logic [1:0]         ld_kind;
  logic signed [21:0] cx, cy;
  logic [16:0]        cu, cv;
  logic signed [24:0] sx, sy;
  logic signed [23:0] vx, vy;

  function automatic logic signed [21:0] rnd14(input logic signed [37:0] v);
    logic signed [37:0] n;
    n = v + 38'sd8192;
    return n[35:14];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v[24] != v[23]) return v[24] ? 24'sh800000 : 24'sh7FFFFF;
    return v[23:0];
  endfunction

  assign f_val = {1'b0, cmd_q.angle[13:0]};
  assign g_val = 15'd16384 - f_val;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      StZ2F:        begin mul_a = 21'(f_val); mul_b = 17'(f_val); end
      StZ2G:        begin mul_a = 21'(g_val); mul_b = 17'(g_val); end
      StT1F, StT1G: begin mul_a = 21'sd1160; mul_b = 17'(z2_q); end
      StT2F, StT2G: begin mul_a = 21'sd10512 - 21'(t_q); mul_b = 17'(z2_q); end
      StPF:         begin mul_a = 21'(t_q); mul_b = 17'(f_val); end
      StPG:         begin mul_a = 21'(t_q); mul_b = 17'(g_val); end
      StWc:         begin mul_a = 21'(cmd_q.width); mul_b = cs_q; end
      StWs:         begin mul_a = 21'(cmd_q.width); mul_b = sn_q; end
      StHs:         begin mul_a = 21'(cmd_q.height); mul_b = sn_q; end
      StHc:         begin mul_a = 21'(cmd_q.height); mul_b = cs_q; end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign shr     = prod[37:14];
  assign clamped = (shr > 24'sd16384) ? 15'd16384 : shr[14:0];
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    case (corner_q)
      2'd0:    begin cx = '0;       cy = '0;       end
      2'd1:    begin cx = rx_q[1]; cy = ry_q[1]; end
      2'd2:    begin cx = rx_q[2]; cy = ry_q[2]; end
      default: begin cx = rx_q[3]; cy = ry_q[3]; end
    endcase
    cu = (corner_q == 2'd1 || corner_q == 2'd2) ? cmd_q.uv_right : {1'b0, cmd_q.uv_left};
    cv = corner_q[1] ? cmd_q.uv_bottom : {1'b0, cmd_q.uv_top};
    sx = 25'(cx) + 25'(cmd_q.pos_x);
    sy = 25'(cy) + 25'(cmd_q.pos_y);
    vx = sat24(sx);
    vy = sat24(sy);
  end

  always_comb begin
    pop_o   = 1'b0;
    load    = 1'b0;
    ld_cmd  = cmd_i;
    ld_kind = KIND_VERTEX;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (cmd_i.op == CMD_SPRITE) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            pop_o   = 1'b1;
            load    = 1'b1;
            ld_kind = (cmd_i.op == CMD_FLUSH) ? KIND_FLUSH : KIND_BIND;
          end
        end
      end
      B_EMIT: begin
        ld_cmd = cmd_q;
        load   = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_o && cmd_i.op == CMD_SPRITE) begin
      cmd_q <= cmd_i;
    end
    if (state_q == B_CALC) begin
      case (step_q)
        StZ2F, StZ2G: z2_q <= shr[14:0];
        StT1F, StT1G: t_q  <= shr[15:0];
        StT2F, StT2G: t_q  <= 16'd25736 - shr[15:0];
        StPF:         pf_q <= clamped;
        StPG:         pg_q <= clamped;
        StTrig: begin
          if (cmd_q.angle == '0) begin
            cs_q <= 17'sd16384;
            sn_q <= '0;
          end else begin
            case (cmd_q.angle[15:14])
              2'd0:    begin sn_q <= 17'(pf_q);  cs_q <= 17'(pg_q);  end
              2'd1:    begin sn_q <= 17'(pg_q);  cs_q <= -17'(pf_q); end
              2'd2:    begin sn_q <= -17'(pf_q); cs_q <= -17'(pg_q); end
              default: begin sn_q <= -17'(pg_q); cs_q <= 17'(pf_q);  end
            endcase
          end
        end
        StWc: wc_q <= prod;
        StWs: ws_q <= prod;
        StHs: hs_q <= prod;
        StHc: hc_q <= prod;
        StRound: begin
          rx_q[1] <= rnd14(wc_q);
          ry_q[1] <= rnd14(ws_q);
          rx_q[2] <= rnd14(wc_q - hs_q);
          ry_q[2] <= rnd14(ws_q + hc_q);
          rx_q[3] <= rnd14(-hs_q);
          ry_q[3] <= rnd14(hc_q);
        end
        default: ;
      endcase
    end
    if (load) begin
      kind_o <= ld_kind;
      if (state_q == B_EMIT) begin
        vert_x_o         <= vx;
        vert_y_o         <= vy;
        tex_u_o          <= cu;
        tex_v_o          <= cv;
        slot_o           <= ld_cmd.slot;
        bound_handle_o   <= '0;
        batch_vertices_o <= '0;
        batch_textures_o <= '0;
        last_o           <= (corner_q == 2'd3) && ld_cmd.last;
      end else if (ld_cmd.op == CMD_FLUSH) begin
        vert_x_o         <= '0;
        vert_y_o         <= '0;
        tex_u_o          <= '0;
        tex_v_o          <= '0;
        slot_o           <= '0;
        bound_handle_o   <= '0;
        batch_vertices_o <= ld_cmd.batch_vertices;
        batch_textures_o <= ld_cmd.batch_textures;
        last_o           <= ld_cmd.last;
      end else begin
        vert_x_o         <= '0;
        vert_y_o         <= '0;
        tex_u_o          <= '0;
        tex_v_o          <= '0;
        slot_o           <= ld_cmd.slot;
        bound_handle_o   <= ld_cmd.handle;
        batch_vertices_o <= '0;
        batch_textures_o <= '0;
        last_o           <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      corner_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o && cmd_i.op == CMD_SPRITE) begin
            state_q <= B_CALC;
            step_q  <= (cmd_i.angle == '0) ? StTrig : StZ2F;
          end
        end
        B_CALC: begin
          if (step_q == StRound) begin
            state_q  <= B_EMIT;
            corner_q <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        B_EMIT: begin
          if (load) begin
            corner_q <= corner_q + 1'b1;
            if (corner_q == 2'd3) state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== design/sprite_quad_batcher.sv =====
// Sprite batcher top level: front, command queue and back.
//
//  channel | direction | handshake                | word
//  in      | input     | in_valid_i / in_ready_o  | mode, texture, position, size, angle, UV
//  out     | output    | out_valid_o/out_ready_i  | vertex, batch flush or slot bind
//
// The front takes a new word only when idle, steps through flush, bind and sprite states,
// and queues up to three commands per word into a four-entry queue.
// The back loads a flush or bind result straight from the queue; a sprite runs its steps
// in the shared multiplier, skipping the sine steps without rotation, then emits four vertex words.
// Reset clears the counters, queue and output valid flag; slot entries stay unset.
// Either side may stall; the queue and the output register hold work in place.
module sprite_quad_batcher #(
  parameter int unsigned MAX_SPRITES = 1024,
  parameter int unsigned TEX_SLOTS   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [15:0]        texture_handle_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic [19:0]        width_i,
  input  logic [19:0]        height_i,
  input  logic [15:0]        angle_i,
  input  logic [15:0]        uv_left_i,
  input  logic [15:0]        uv_top_i,
  input  logic [15:0]        uv_width_i,
  input  logic [15:0]        uv_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [23:0] vert_x_o,
  output logic signed [23:0] vert_y_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [2:0]         slot_o,
  output logic [15:0]        bound_handle_o,
  output logic [12:0]        batch_vertices_o,
  output logic [3:0]         batch_textures_o,
  output logic               last_o
);
  import sqb_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;

  sqb_front #(
    .MAX_SPRITES(MAX_SPRITES),
    .TEX_SLOTS  (TEX_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .texture_handle_i,
    .pos_x_i,
    .pos_y_i,
    .width_i,
    .height_i,
    .angle_i,
    .uv_left_i,
    .uv_top_i,
    .uv_width_i,
    .uv_height_i,
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  sqb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_cmd)
  );

  sqb_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .vert_x_o,
    .vert_y_o,
    .tex_u_o,
    .tex_v_o,
    .slot_o,
    .bound_handle_o,
    .batch_vertices_o,
    .batch_textures_o,
    .last_o
  );
endmodule

// ===== sim/sprite_quad_batcher_tb.sv =====
// Self-checking testbench of the sprite quad batcher: directed and random sprite pushes.
module sprite_quad_batcher_tb;
  import sqb_pkg::*;

  localparam int unsigned MAX_SPR = 1024;
  localparam int unsigned SLOTS = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               mode;
    logic [15:0]        handle;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [19:0]        width;
    logic [19:0]        height;
    logic [15:0]        angle;
    logic [15:0]        uv_left;
    logic [15:0]        uv_top;
    logic [15:0]        uv_width;
    logic [15:0]        uv_height;
  } sprite_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [2:0]         slot;
    logic [15:0]        handle;
    logic [12:0]        bverts;
    logic [3:0]         btex;
    logic               last;
  } vert_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sprite_t drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic signed [23:0] vert_x_o, vert_y_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [2:0] slot_o;
  logic [15:0] bound_handle_o;
  logic [12:0] batch_vertices_o;
  logic [3:0] batch_textures_o;
  logic last_o;

  vert_word_t expected_words[$];
  logic [15:0] bound_table[SLOTS];
  int unsigned bound_count;
  int unsigned vert_total;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic rand_handles = 1'b0;

  always #1 clk_i = ~clk_i;

  sprite_quad_batcher #(.MAX_SPRITES(MAX_SPR), .TEX_SLOTS(SLOTS)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .mode_i(drv.mode), .texture_handle_i(drv.handle), .pos_x_i(drv.pos_x),
    .pos_y_i(drv.pos_y), .width_i(drv.width), .height_i(drv.height),
    .angle_i(drv.angle), .uv_left_i(drv.uv_left), .uv_top_i(drv.uv_top),
    .uv_width_i(drv.uv_width), .uv_height_i(drv.uv_height),
    .out_valid_o, .out_ready_i, .kind_o, .vert_x_o, .vert_y_o, .tex_u_o, .tex_v_o,
    .slot_o, .bound_handle_o, .batch_vertices_o, .batch_textures_o, .last_o
  );

  function automatic longint quarter_sine(longint z);
    longint z2, t;
    z2 = (z * z) >>> 14;
    t = (1160 * z2) >>> 14;
    t = ((10512 - t) * z2) >>> 14;
    t = 25736 - t;
    t = (t * z) >>> 14;
    if (t > 16384) t = 16384;
    if (t < 0) t = 0;
    return t;
  endfunction

  function automatic longint round_q14(longint a);
    longint n;
    n = a + 8192;
    if (n >= 0) return n >>> 14;
    return -((-n + 16383) >>> 14);
  endfunction

  function automatic logic signed [23:0] clamp_pos(longint a);
    if (a > 8388607) return 24'sd8388607;
    if (a < -8388608) return -24'sd8388608;
    return a[23:0];
  endfunction

  function automatic void push_flush();
    vert_word_t w;
    w = '0;
    w.kind = KIND_FLUSH;
    w.bverts = vert_total[12:0];
    w.btex = bound_count[3:0];
    expected_words.push_back(w);
    vert_total = 0;
    bound_count = 0;
  endfunction

  // Predict the words caused by one accepted item.
  function automatic void predict_quad(sprite_t s);
    vert_word_t w;
    int unsigned slot_idx, first;
    logic hit;
    longint f, pf, pg, sn, cs, cx, cy, rx, ry;
    first = expected_words.size();
    if (s.mode) begin
      if (vert_total != 0) push_flush();
    end else begin
      if (vert_total >= MAX_SPR * CORNERS) push_flush();
      if (bound_count >= SLOTS) push_flush();
      hit = 1'b0;
      slot_idx = 0;
      for (int i = 0; i < bound_count; i++)
        if (!hit && bound_table[i] == s.handle) begin
          hit = 1'b1;
          slot_idx = i;
        end
      if (!hit) begin
        slot_idx = bound_count;
        bound_table[slot_idx] = s.handle;
        bound_count++;
        w = '0;
        w.kind = KIND_BIND;
        w.slot = slot_idx[2:0];
        w.handle = s.handle;
        expected_words.push_back(w);
      end
      sn = 0;
      cs = 16384;
      if (s.angle != 0) begin
        f = s.angle[13:0];
        pf = quarter_sine(f);
        pg = quarter_sine(16384 - f);
        case (s.angle[15:14])
          2'd0: begin sn = pf; cs = pg; end
          2'd1: begin sn = pg; cs = -pf; end
          2'd2: begin sn = -pf; cs = -pg; end
          default: begin sn = -pg; cs = pf; end
        endcase
      end
      for (int c = 0; c < CORNERS; c++) begin
        cx = (c == 1 || c == 2) ? longint'(s.width) : 0;
        cy = (c >= 2) ? longint'(s.height) : 0;
        rx = cx;
        ry = cy;
        if (s.angle != 0) begin
          rx = round_q14(cx * cs - cy * sn);
          ry = round_q14(cx * sn + cy * cs);
        end
        w = '0;
        w.kind = KIND_VERTEX;
        w.vx = clamp_pos(rx + longint'(s.pos_x));
        w.vy = clamp_pos(ry + longint'(s.pos_y));
        w.u = (c == 1 || c == 2) ? {1'b0, s.uv_left} + s.uv_width : {1'b0, s.uv_left};
        w.v = (c >= 2) ? {1'b0, s.uv_top} + s.uv_height : {1'b0, s.uv_top};
        w.slot = slot_idx[2:0];
        expected_words.push_back(w);
      end
      vert_total += CORNERS;
    end
    if (expected_words.size() > first) expected_words[$].last = 1'b1;
  endfunction

  task automatic send_sprite(sprite_t s);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv <= s;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_quad(s);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i)
    if (rst_ni) out_ready_i <= ($urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;

  always @(posedge clk_i) begin
    vert_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word kind %0d", kind_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (kind_o !== e.kind) begin $error("kind exp %0d got %0d", e.kind, kind_o); errors++; end
        if (vert_x_o !== e.vx) begin $error("vert_x exp %0d got %0d", e.vx, vert_x_o); errors++; end
        if (vert_y_o !== e.vy) begin $error("vert_y exp %0d got %0d", e.vy, vert_y_o); errors++; end
        if (tex_u_o !== e.u) begin $error("tex_u exp %0d got %0d", e.u, tex_u_o); errors++; end
        if (tex_v_o !== e.v) begin $error("tex_v exp %0d got %0d", e.v, tex_v_o); errors++; end
        if (slot_o !== e.slot) begin $error("slot exp %0d got %0d", e.slot, slot_o); errors++; end
        if (bound_handle_o !== e.handle) begin
          $error("bound_handle exp %0d got %0d", e.handle, bound_handle_o); errors++;
        end
        if (batch_vertices_o !== e.bverts) begin
          $error("batch_vertices exp %0d got %0d", e.bverts, batch_vertices_o); errors++;
        end
        if (batch_textures_o !== e.btex) begin
          $error("batch_textures exp %0d got %0d", e.btex, batch_textures_o); errors++;
        end
        if (last_o !== e.last) begin $error("last exp %0d got %0d", e.last, last_o); errors++; end
      end
    end
  end

  function automatic sprite_t rand_sprite();
    sprite_t s;
    logic [223:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    s = r[$bits(sprite_t)-1:0];
    s.mode = ($urandom_range(0, 9) == 0);
    // draw from a small handle pool so slots get reused
    if (!rand_handles) s.handle = 16'($urandom_range(0, 11));
    if ($urandom_range(0, 3) == 0) s.angle = '0;
    if ($urandom_range(0, 2) == 0) begin
      s.width = 20'($urandom_range(0, 4096));
      s.height = 20'($urandom_range(0, 4096));
    end
    return s;
  endfunction

  task automatic wait_drained();
    idle_input();
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_extremes();
    sprite_t s;
    s = '0;
    send_sprite(s);
    s = '1;
    s.mode = 1'b0;
    send_sprite(s);
    s.pos_x = -24'sd8388608;
    s.pos_y = -24'sd8388608;
    s.angle = 16'h8000;
    send_sprite(s);
    for (int q = 0; q < 4; q++) begin
      s = rand_sprite();
      s.mode = 1'b0;
      s.angle = 16'(q * 16'h4000 + ((q == 0) ? 1 : 0));
      send_sprite(s);
    end
    s.angle = 16'h2000;
    send_sprite(s);
    s.mode = 1'b1;
    send_sprite(s);
    send_sprite(s);
  endtask

  task automatic test_slots_full();
    sprite_t s;
    for (int i = 0; i < SLOTS + 3; i++) begin
      s = rand_sprite();
      s.mode = 1'b0;
      s.handle = (i == SLOTS + 1) ? 16'd0 : 16'(i);
      send_sprite(s);
    end
    wait_drained();
    s.mode = 1'b1;
    send_sprite(s);
  endtask

  task automatic test_random();
    for (int i = 0; i < 88; i++) begin
      rand_handles = (i >= 70);
      send_sprite(rand_sprite());
    end
  endtask

  initial begin
    bound_count = 0;
    vert_total = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_slots_full();
    test_random();
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/sqb_pkg.sv
design/sqb_queue.sv
design/sqb_front.sv
design/sqb_back.sv
design/sprite_quad_batcher.sv
sim/sprite_quad_batcher_tb.sv
